FILE: rtl/sobel_gradient_magnitude_defines.svh
// Assertion macros for the Sobel gradient magnitude block.
// Used by the top level only.
`ifndef SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SGM_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SGM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define SGM_ASSERT_IMPL(label, clk, rst_n, a, c)
`define SGM_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/sgm_pkg.sv
// Package for the Sobel gradient magnitude block: types and constants.
// No dependencies.
`timescale 1ns / 1ps
package sgm_pkg;
    localparam int MAX_WIDTH_DEF = 8192;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
    localparam int SQ_W = 22;
    localparam int ROOT_STEPS = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_ROOT,
        ST_EDGE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic restart;
        logic load;
        logic read;
        logic update;
        logic edge_shift;
        logic root_step;
        logic root_init;
    } t_cmd;

    typedef struct packed {
        logic col_zero;
        logic row_ge2;
        logic frame_end;
        logic emit_mid;
        logic mid_done;
        logic root_done;
    } t_status;
endpackage

FILE: rtl/sgm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/sgm_ctrl.sv
// Controller state machine of the Sobel block.
// Depends on sgm_pkg.
`timescale 1ns / 1ps
module sgm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  logic             i_cfg_we,
    input  sgm_pkg::t_status i_status,
    output sgm_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    sgm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgm_pkg::ST_IDLE: begin
                if (i_cfg_we) begin
                    n_state = sgm_pkg::ST_IDLE;
                end else if (i_in_valid) begin
                    n_state = sgm_pkg::ST_READ;
                end
            end
            sgm_pkg::ST_READ: begin
                if (i_status.col_zero && i_status.row_ge2) begin
                    n_state = sgm_pkg::ST_EDGE;
                end else begin
                    n_state = sgm_pkg::ST_CALC;
                end
            end
            sgm_pkg::ST_EDGE: n_state = sgm_pkg::ST_ROOT;
            sgm_pkg::ST_CALC: begin
                n_state = i_status.emit_mid ? sgm_pkg::ST_EDGE : sgm_pkg::ST_IDLE;
            end
            sgm_pkg::ST_ROOT: begin
                if (i_status.root_done) begin
                    n_state = sgm_pkg::ST_OUT;
                end
            end
            sgm_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_state = (i_status.frame_end || i_status.mid_done) ?
                              sgm_pkg::ST_IDLE : sgm_pkg::ST_CALC;
                end
            end
            default: n_state = sgm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.restart = i_cfg_we;
        unique case (r_state)
            sgm_pkg::ST_IDLE: begin
                o_in_ready = !i_cfg_we;
                o_cmd.load = i_in_valid && !i_cfg_we;
                o_cmd.read = o_cmd.load;
            end
            sgm_pkg::ST_READ: begin
                o_cmd.edge_shift = i_status.col_zero && i_status.row_ge2;
                o_cmd.root_init = o_cmd.edge_shift;
            end
            sgm_pkg::ST_EDGE: o_cmd.root_init = 1'b1;
            sgm_pkg::ST_CALC: o_cmd.update = 1'b1;
            sgm_pkg::ST_ROOT: o_cmd.root_step = 1'b1;
            sgm_pkg::ST_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

FILE: rtl/sgm_datapath.sv
// Datapath of the Sobel block: line stores, window, counters, square root.
// Depends on sgm_pkg and sgm_ram.
`timescale 1ns / 1ps
module sgm_datapath #(
    parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sgm_pkg::t_cmd    i_cmd,
    input  logic             i_out_ready,
    input  logic             i_cfg_we,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]       i_pixel,
    input  logic             i_flush,
    output sgm_pkg::t_status o_status,
    output logic [7:0]       o_magnitude,
    output logic             o_frame_last
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [13:0] r_width;
    logic [15:0] r_height;
    logic [AW-1:0] r_col;
    logic [16:0] r_row;
    logic [7:0] r_win [9];
    logic [7:0] r_pix;
    logic r_last;
    logic [sgm_pkg::SQ_W-1:0] r_v, r_res, r_bit;
    logic [3:0] r_cnt;
    logic r_mid_done;
    logic [7:0] w_up, w_lo, w_p;
    logic [WW-1:0] w_weff;
    logic [16:0] w_heff;
    logic [7:0] w_nb [9];
    logic signed [11:0] w_gx, w_gy;
    logic [sgm_pkg::SQ_W-1:0] w_sq;
    logic [sgm_pkg::SQ_W:0] w_trial;
    logic w_edge;

    always_comb begin
        if (r_width == '0) begin
            w_weff = WW'(1);
        end else if ({1'b0, r_width} > 15'(MAX_WIDTH)) begin
            w_weff = WW'(MAX_WIDTH);
        end else begin
            w_weff = WW'(r_width);
        end
        w_heff = (r_height == '0) ? 17'd1 : {1'b0, r_height};
    end

    assign w_p = (!i_flush && r_row < w_heff) ? i_pixel : 8'd0;

    sgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk(i_clk), .i_we(i_cmd.update), .i_addr(r_col),
        .i_wdata(w_lo), .o_rdata(w_up)
    );
    logic [7:0] w_lo_raw, w_up_raw;
    assign w_lo = w_lo_raw;
    sgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk(i_clk), .i_we(i_cmd.update), .i_addr(r_col),
        .i_wdata(r_pix), .o_rdata(w_lo_raw)
    );
    assign w_up_raw = w_up;

    assign w_edge = (r_col == '0) && (r_row >= 17'd2);

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_nb[k] = r_win[k];
        end
        if (w_edge && !r_mid_done) begin
            for (int k = 0; k < 3; k++) begin
                w_nb[k*3] = r_win[k*3+1];
                w_nb[k*3+1] = r_win[k*3+2];
                w_nb[k*3+2] = 8'd0;
            end
        end
        w_gx = (12'(w_nb[0]) + 12'(w_nb[3]) * 12'sd2 + 12'(w_nb[6]))
             - (12'(w_nb[2]) + 12'(w_nb[5]) * 12'sd2 + 12'(w_nb[8]));
        w_gy = (12'(w_nb[0]) + 12'(w_nb[1]) * 12'sd2 + 12'(w_nb[2]))
             - (12'(w_nb[6]) + 12'(w_nb[7]) * 12'sd2 + 12'(w_nb[8]));
        w_sq = sgm_pkg::SQ_W'(w_gx * w_gx) + sgm_pkg::SQ_W'(w_gy * w_gy);
        w_trial = {1'b0, r_res} + {1'b0, r_bit};
    end

    logic w_mid_emit;
    assign w_mid_emit = (r_col != '0) && (r_row >= 17'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 14'd8192;
            r_height <= 16'd1;
            r_col <= '0;
            r_row <= '0;
            r_mid_done <= 1'b0;
            r_last <= 1'b0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == sgm_pkg::REG_WIDTH) r_width <= i_cfg_data[13:0];
            if (i_cfg_idx == sgm_pkg::REG_HEIGHT) r_height <= i_cfg_data;
            r_col <= '0;
            r_row <= '0;
            r_mid_done <= 1'b0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else begin
            if (i_cmd.load) begin
                r_pix <= w_p;
                r_mid_done <= 1'b0;
            end
            if (i_cmd.edge_shift) begin
                r_last <= (r_row == w_heff + 17'd1);
            end
            if (i_cmd.update) begin
                r_mid_done <= 1'b1;
                if (r_col != '0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[k*3] <= r_win[k*3+1];
                        r_win[k*3+1] <= r_win[k*3+2];
                    end
                end else begin
                    for (int k = 0; k < 9; k++) r_win[k] <= '0;
                end
                r_win[2] <= (r_row >= 17'd2) ? w_up_raw : 8'd0;
                r_win[5] <= (r_row >= 17'd1) ? w_lo : 8'd0;
                r_win[8] <= r_pix;
                r_last <= 1'b0;
                if (WW'({1'b0, r_col}) + WW'(1) >= w_weff) begin
                    r_col <= '0;
                    r_row <= r_row + 17'd1;
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
            if (i_out_ready && r_last && r_cnt == '0 && r_bit == '0 && o_status.frame_end) begin
                r_col <= '0;
                r_row <= '0;
                for (int k = 0; k < 9; k++) r_win[k] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_bit <= '0;
        end else if (i_cmd.root_init) begin
            r_v <= w_sq;
            r_res <= '0;
            r_bit <= sgm_pkg::SQ_W'(1) << (sgm_pkg::SQ_W - 2);
            r_cnt <= 4'(sgm_pkg::ROOT_STEPS);
        end else if (i_cmd.root_step && r_cnt != '0) begin
            if ({1'b0, r_v} >= w_trial) begin
                r_v <= r_v - w_trial[sgm_pkg::SQ_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt - 4'd1;
        end
    end

    assign o_status.col_zero = (r_col == '0);
    assign o_status.row_ge2 = (r_row >= 17'd2);
    assign o_status.frame_end = r_last;
    assign o_status.emit_mid = w_mid_emit;
    assign o_status.mid_done = r_mid_done;
    assign o_status.root_done = (r_cnt == 4'd1);
    assign o_magnitude = (r_res > sgm_pkg::SQ_W'(255)) ? 8'hFF : r_res[7:0];
    assign o_frame_last = r_last;
endmodule

FILE: rtl/sobel_gradient_magnitude.sv
// Top level of the Sobel gradient magnitude block.
// Depends on sgm_pkg, sgm_ctrl, sgm_datapath and the defines header.
// Usage:
//   s_axis carries one item per transaction: tdata holds the pixel and tuser
//   the flush flag. m_axis carries a result: tdata holds the magnitude and
//   tlast marks the final pixel of the frame.
//   Configuration writes (index 0 width, 1 height) restart the frame position.
//   The user must make them only while the block is idle; it does not check.
//   The first width+1 items of a frame give no result. A result runs through
//   READ, CALC (not at the right edge), EDGE and ROOT before tvalid rises.
//   A new item is accepted only in the idle state, after the result of the
//   previous item, if any, has left the 11-step square root and been taken.
//   An item gives at most one result.
//   Reset: synchronous, active low; width 8192, height 1, window cleared.
//   Line store contents are masked by the row count until rewritten.
//   When the receiver stalls the result holds in its register and no new
//   item is accepted until it is taken.
`timescale 1ns / 1ps
`include "sobel_gradient_magnitude_defines.svh"
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel[7:0]
    input  logic        s_axis_tuser,   // flush[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // magnitude[7:0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    sgm_pkg::t_cmd w_cmd;
    sgm_pkg::t_status w_status;
    logic w_out_stall;

    sgm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_out_ready(m_axis_tready), .i_cfg_we(i_cfg_we), .i_status(w_status),
        .o_cmd(w_cmd), .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    sgm_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_out_ready(m_axis_tready && m_axis_tvalid),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_pixel(s_axis_tdata), .i_flush(s_axis_tuser),
        .o_status(w_status), .o_magnitude(m_axis_tdata), .o_frame_last(m_axis_tlast)
    );

    assign w_out_stall = m_axis_tvalid && !m_axis_tready;

    `SGM_ASSERT_IMPL(a_no_accept_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `SGM_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, w_out_stall, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

FILE: tb/sv/sobel_gradient_magnitude_test.sv
// Self-checking testbench for the streaming Sobel gradient magnitude block.
// Predicts each magnitude and frame-end flag in step with accepted input transactions.
// Depends on sgm_pkg and sobel_gradient_magnitude.
`timescale 1ns / 1ps
module sobel_gradient_magnitude_test;
    localparam int MAXW = sgm_pkg::MAX_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [7:0] magnitude;
        logic       frame_last;
    } t_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata;
    logic                           s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [7:0]                     m_axis_tdata;
    logic                           m_axis_tlast;
    logic                           i_cfg_we;
    logic [sgm_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [sgm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    sobel_gradient_magnitude DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // pending pixel transactions: {flush, pixel}
    logic [8:0] pixel_queue[$];
    t_result    magnitude_queue[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         cycles = 0;

    // predictor state
    int         cfg_width;
    int         cfg_height;
    logic [7:0] row_above[MAXW];
    logic [7:0] row_prev[MAXW];
    int         win[9];
    int         in_col;
    int         in_row;

    function automatic int grad_mag(input int n[9]);
        int gx;
        int gy;
        int sq;
        int m;
        gx = (n[0] + 2 * n[3] + n[6]) - (n[2] + 2 * n[5] + n[8]);
        gy = (n[0] + 2 * n[1] + n[2]) - (n[6] + 2 * n[7] + n[8]);
        sq = gx * gx + gy * gy;
        m = 0;
        while (m < 255 && (m + 1) * (m + 1) <= sq) m++;
        return m;
    endfunction

    task automatic restart_position();
        in_col = 0;
        in_row = 0;
        for (int k = 0; k < 9; k++) win[k] = 0;
    endtask

    task automatic sobel_advance(input logic [7:0] pix, input logic flush);
        int w;
        int h;
        int nb[9];
        int p;
        int up;
        int lo;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAXW) ? MAXW : cfg_width);
        h = (cfg_height == 0) ? 1 : cfg_height;
        if (in_col == 0) begin
            if (in_row >= 2) begin
                for (int k = 0; k < 3; k++) begin
                    nb[k * 3] = win[k * 3 + 1];
                    nb[k * 3 + 1] = win[k * 3 + 2];
                    nb[k * 3 + 2] = 0;
                end
                magnitude_queue.push_back({8'(grad_mag(nb)), in_row == h + 1});
                if (in_row == h + 1) begin
                    restart_position();
                    return;
                end
            end
            for (int k = 0; k < 9; k++) win[k] = 0;
        end
        p = (!flush && in_row < h) ? int'(pix) : 0;
        up = (in_row >= 2) ? int'(row_above[in_col]) : 0;
        lo = (in_row >= 1) ? int'(row_prev[in_col]) : 0;
        row_above[in_col] = row_prev[in_col];
        row_prev[in_col] = 8'(p);
        if (in_col > 0) begin
            for (int k = 0; k < 3; k++) begin
                win[k * 3] = win[k * 3 + 1];
                win[k * 3 + 1] = win[k * 3 + 2];
            end
        end
        win[2] = up;
        win[5] = lo;
        win[8] = p;
        if (in_col > 0 && in_row >= 1) begin
            for (int k = 0; k < 9; k++) nb[k] = win[k];
            magnitude_queue.push_back({8'(grad_mag(nb)), 1'b0});
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sobel_advance(s_axis_tdata, s_axis_tuser);
                void'(pixel_queue.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_axis_tdata <= pixel_queue[0][7:0];
                    s_axis_tuser <= pixel_queue[0][8];
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (magnitude_queue.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, -1);
                end else begin
                    if (m_axis_tdata !== magnitude_queue[0].magnitude)
                        report_mismatch("magnitude", m_axis_tdata, magnitude_queue[0].magnitude);
                    if (m_axis_tlast !== magnitude_queue[0].frame_last)
                        report_mismatch("frame_last", m_axis_tlast,
                                        magnitude_queue[0].frame_last);
                    void'(magnitude_queue.pop_front());
                end
            end
        end
    end

    task automatic wait_quiet();
        while (pixel_queue.size() > 0 || s_axis_tvalid || magnitude_queue.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sgm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sgm_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx == sgm_pkg::REG_WIDTH) cfg_width = value & 16'h3FFF;
        else cfg_height = value;
        restart_position();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [15:0] w, input logic [15:0] h);
        wait_quiet();
        write_reg(sgm_pkg::REG_WIDTH, w);
        write_reg(sgm_pkg::REG_HEIGHT, h);
    endtask

    // frame pixels with occasional early flush, then the drain tail with stray pixels
    task automatic queue_frame(input int w, input int h, input int flush_pct,
                               input int stray_pct, input int tail_len);
        for (int k = 0; k < w * h; k++)
            pixel_queue.push_back({1'($urandom_range(99, 0) < flush_pct),
                                   8'($urandom_range(255, 0))});
        for (int k = 0; k < tail_len; k++)
            pixel_queue.push_back({1'($urandom_range(99, 0) >= stray_pct),
                                   8'($urandom_range(255, 0))});
    endtask

    int w;
    int h;
    int tail;
    int mode;
    int sent;

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cfg_width = MAXW;
        cfg_height = 1;
        for (int k = 0; k < MAXW; k++) begin
            row_above[k] = 8'h00;
            row_prev[k] = 8'h00;
        end
        restart_position();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 frame with extreme pixels, an early flush and a stray pixel in the tail
        set_geometry(16'd3, 16'd3);
        pixel_queue.push_back({1'b0, 8'hFF});
        pixel_queue.push_back({1'b0, 8'h00});
        pixel_queue.push_back({1'b0, 8'hFF});
        pixel_queue.push_back({1'b0, 8'h00});
        pixel_queue.push_back({1'b1, 8'hFF});
        pixel_queue.push_back({1'b0, 8'h00});
        pixel_queue.push_back({1'b0, 8'hFF});
        pixel_queue.push_back({1'b0, 8'hFF});
        pixel_queue.push_back({1'b0, 8'hFF});
        pixel_queue.push_back({1'b0, 8'hAA});
        pixel_queue.push_back({1'b1, 8'h55});
        pixel_queue.push_back({1'b1, 8'h00});
        pixel_queue.push_back({1'b1, 8'h00});
        // zero width and height act as one
        set_geometry(16'd0, 16'd0);
        queue_frame(1, 1, 0, 50, 2);
        queue_frame(1, 1, 0, 50, 2);
        // over-range width saturates at the maximum: a partial first row yields nothing
        set_geometry(16'hFFFF, 16'd1);
        queue_frame(100, 1, 2, 5, 0);
        // tallest frame, cut short by the next register write
        set_geometry(16'd4, 16'hFFFF);
        queue_frame(4, 3, 0, 0, 0);

        sent = 0;
        mode = 0;
        while (sent < 1000) begin
            if (mode % 4 == 0) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end else if (mode % 4 == 1) begin
                send_idle_pct = 74;
                recv_stall_pct = 0;
            end else if (mode % 4 == 2) begin
                send_idle_pct = 0;
                recv_stall_pct = 74;
            end else begin
                send_idle_pct = 8;
                recv_stall_pct = 8;
            end
            w = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
            h = $urandom_range(6, 0);
            set_geometry(16'(w), 16'(h));
            if (w == 0) w = 1;
            if (h == 0) h = 1;
            for (int f = $urandom_range(3, 1); f > 0; f--) begin
                tail = ($urandom_range(7, 0) == 0) ? $urandom_range(w, 0) : w + 1;
                queue_frame(w, h, 6, 12, tail);
                sent += w * h + tail;
                if (tail <= w) break;
                if (mode == 5) begin
                    // hold off until every result of this frame is back
                    wait_quiet();
                end
            end
            mode++;
        end

        wait_quiet();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
